@@ src/lfod_pkg.sv @@
package lfod_pkg;

    localparam int MAX_SAMPLES = 2048;

    localparam int RANGE_W = 16;
    localparam int CNT_W   = 12;
    localparam int SUM_W   = 28;
    localparam int ANG_W   = 32;
    localparam int HALF_W  = 22;
    localparam int START_W = 24;
    localparam int STEP_W  = 23;
    localparam int PROD_W  = SUM_W + CNT_W;
    localparam int CS_W    = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [CNT_W-1:0] CNT_CAP =
        CNT_W'((MAX_SAMPLES > 4095) ? 4095 : MAX_SAMPLES);

    localparam logic signed [ANG_W-1:0] ANGLE_CEIL  = 32'sh7FFF_FFFF;
    localparam logic signed [ANG_W-1:0] ONE_RAD     = 32'sd1000000;
    localparam logic signed [ANG_W-1:0] NEG_ONE_RAD = -32'sd1000000;

    localparam logic [CS_W-1:0] CLEAR_SCANS_NEEDED = 3'd5;
    localparam logic [CS_W-1:0] CLEAR_SCANS_MAX    = 3'd7;

    localparam logic [RANGE_W-1:0] NEAREST_NONE = 16'hFFFF;

    // register index codes (byte address = 4 * index)
    localparam logic [2:0] REG_STOP_DIST     = 3'd0;
    localparam logic [2:0] REG_CLEAR_DIST    = 3'd1;
    localparam logic [2:0] REG_FRONT_HALF    = 3'd2;
    localparam logic [2:0] REG_REQUIRED_HITS = 3'd3;
    localparam logic [2:0] REG_RANGE_MAX     = 3'd4;
    localparam logic [2:0] REG_ANGLE_START   = 3'd5;
    localparam logic [2:0] REG_ANGLE_STEP    = 3'd6;

    typedef struct packed {
        logic [RANGE_W-1:0]        stop_dist_mm;
        logic [RANGE_W-1:0]        clear_dist_mm;
        logic [HALF_W-1:0]         front_half_angle_urad;
        logic [CNT_W-1:0]          required_hits;
        logic [RANGE_W-1:0]        max_range_mm;
        logic signed [START_W-1:0] angle_start_urad;
        logic [STEP_W-1:0]         angle_step_urad;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]   hits;
        logic [RANGE_W-1:0] nearest;
        logic               front_seen;
        logic [SUM_W-1:0]   left_sum;
        logic [CNT_W-1:0]   left_cnt;
        logic [SUM_W-1:0]   right_sum;
        logic [CNT_W-1:0]   right_cnt;
    } scan_sum_t;

    typedef struct packed {
        logic               path_blocked;
        logic               detour_left;
        logic               obstacle_seen;
        logic [RANGE_W-1:0] nearest_front_mm;
        logic [CNT_W-1:0]   hit_total;
    } result_t;

endpackage

@@ src/lfod_sample_if.sv @@
interface lfod_sample_if;
    import lfod_pkg::*;

    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_mm;
    logic               range_valid;
    logic               scan_end;

    modport source (output valid, range_mm, range_valid, scan_end, input ready);
    modport sink (input valid, range_mm, range_valid, scan_end, output ready);
endinterface

@@ src/lfod_result_if.sv @@
interface lfod_result_if;
    import lfod_pkg::*;

    logic               valid;
    logic               ready;
    logic               path_blocked;
    logic               detour_left;
    logic               obstacle_seen;
    logic [RANGE_W-1:0] nearest_front_mm;
    logic [CNT_W-1:0]   hit_total;

    modport source (output valid, path_blocked, detour_left, obstacle_seen,
                    nearest_front_mm, hit_total, input ready);
    modport sink (input valid, path_blocked, detour_left, obstacle_seen,
                  nearest_front_mm, hit_total, output ready);
endinterface

@@ src/lidar_front_obstacle_detector.sv @@
// LiDAR front obstacle detector.
// sample_ch carries one range sample per request (range_mm, range_valid,
// scan_end). The beam angle starts at angle_start_urad on the first sample
// of a scan and advances by angle_step_urad per sample, valid or not.
// result_ch carries one request per scan, issued for the sample marked
// scan_end; other samples produce nothing.
// Configuration is written over the APB port (register i at byte 4*i,
// pready always high); the user must write it only while the block is idle;
// the block itself does not enforce this. Throughput: one sample per cycle
// while no stalled scan end holds the input register, set by the accumulate
// stage behind it. A scan-end sample passes the input register, snapshot,
// product register and result register before its result shows.
// Reset clears the current scan, the blocked state, the clear-scan count
// and the detour side, and loads the register defaults.
// When result_ch stalls, up to four scan ends are held in the pipeline;
// ordinary samples keep flowing, and sample_ch.ready drops only when a
// scan end cannot move on.
module lidar_front_obstacle_detector (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfod_pkg::ADDR_W-1:0] paddr,
    input  logic [lfod_pkg::DATA_W-1:0] pwdata,
    output logic [lfod_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    lfod_sample_if.sink                 sample_ch,
    lfod_result_if.source               result_ch
);
    import lfod_pkg::*;

    cfg_t      cfg;
    scan_sum_t sum;
    logic      sum_valid;
    logic      sum_ready;

    lfod_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfod_scan_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .cfg       (cfg),
        .sum       (sum),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready)
    );

    lfod_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .sum       (sum),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .result_ch (result_ch)
    );
endmodule

@@ src/lfod_cfg_regs.sv @@
module lfod_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfod_pkg::ADDR_W-1:0] paddr,
    input  logic [lfod_pkg::DATA_W-1:0] pwdata,
    output logic [lfod_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lfod_pkg::cfg_t              cfg
);
    import lfod_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_STOP_DIST:     cfg_next.stop_dist_mm          = pwdata[RANGE_W-1:0];
                REG_CLEAR_DIST:    cfg_next.clear_dist_mm         = pwdata[RANGE_W-1:0];
                REG_FRONT_HALF:    cfg_next.front_half_angle_urad = pwdata[HALF_W-1:0];
                REG_REQUIRED_HITS: cfg_next.required_hits         = pwdata[CNT_W-1:0];
                REG_RANGE_MAX:     cfg_next.max_range_mm          = pwdata[RANGE_W-1:0];
                REG_ANGLE_START:   cfg_next.angle_start_urad      = pwdata[START_W-1:0];
                REG_ANGLE_STEP:    cfg_next.angle_step_urad       = pwdata[STEP_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_STOP_DIST:     prdata = DATA_W'(cfg_reg.stop_dist_mm);
            REG_CLEAR_DIST:    prdata = DATA_W'(cfg_reg.clear_dist_mm);
            REG_FRONT_HALF:    prdata = DATA_W'(cfg_reg.front_half_angle_urad);
            REG_REQUIRED_HITS: prdata = DATA_W'(cfg_reg.required_hits);
            REG_RANGE_MAX:     prdata = DATA_W'(cfg_reg.max_range_mm);
            REG_ANGLE_START:   prdata = {{(DATA_W-START_W){1'b0}},
                                         cfg_reg.angle_start_urad};
            REG_ANGLE_STEP:    prdata = DATA_W'(cfg_reg.angle_step_urad);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_dist_mm          <= 16'd1200;
            cfg_reg.clear_dist_mm         <= 16'd1800;
            cfg_reg.front_half_angle_urad <= 22'd698132;
            cfg_reg.required_hits         <= 12'd2;
            cfg_reg.max_range_mm          <= 16'd30000;
            cfg_reg.angle_start_urad      <= -24'sd3141593;
            cfg_reg.angle_step_urad       <= 23'd6136;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

@@ src/lfod_scan_acc.sv @@
module lfod_scan_acc (
    input  logic                 clk,
    input  logic                 rst_n,
    lfod_sample_if.sink          sample_ch,
    input  lfod_pkg::cfg_t       cfg,
    output lfod_pkg::scan_sum_t  sum,
    output logic                 sum_valid,
    input  logic                 sum_ready
);
    import lfod_pkg::*;

    // input register
    logic               s0_valid_reg, s0_valid_next;
    logic [RANGE_W-1:0] s0_range_reg;
    logic               s0_rvalid_reg;
    logic               s0_end_reg;

    // per-scan state
    logic signed [ANG_W-1:0] beam_angle_reg, beam_angle_next;
    logic                    in_scan_reg, in_scan_next;
    logic [CNT_W-1:0]        front_hits_reg, front_hits_next;
    logic [RANGE_W-1:0]      nearest_reg, nearest_next;
    logic                    front_seen_reg, front_seen_next;
    logic [SUM_W-1:0]        left_sum_reg, left_sum_next;
    logic [SUM_W-1:0]        right_sum_reg, right_sum_next;
    logic [CNT_W-1:0]        left_cnt_reg, left_cnt_next;
    logic [CNT_W-1:0]        right_cnt_reg, right_cnt_next;

    logic                    accept;
    logic                    s0_go;
    logic signed [ANG_W-1:0] ang;
    logic [ANG_W-1:0]        ang_mag;
    logic signed [ANG_W:0]   ang_sum;
    logic signed [ANG_W-1:0] ang_adv;
    logic                    in_front, in_left, in_right;
    logic                    hit_inc, left_inc, right_inc, near_upd;
    scan_sum_t               upd;

    assign s0_go           = s0_valid_reg && (!s0_end_reg || sum_ready);
    assign sample_ch.ready = !s0_valid_reg || s0_go;
    assign accept          = sample_ch.valid && sample_ch.ready;

    assign ang = in_scan_reg ? beam_angle_reg
                             : {{(ANG_W-START_W){cfg.angle_start_urad[START_W-1]}},
                                cfg.angle_start_urad};
    assign ang_mag = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
    assign ang_sum = {ang[ANG_W-1], ang} + {{(ANG_W+1-STEP_W){1'b0}}, cfg.angle_step_urad};
    // only a positive overflow is possible; clamp there
    assign ang_adv = (ang_sum[ANG_W:ANG_W-1] == 2'b01) ? ANGLE_CEIL : ang_sum[ANG_W-1:0];

    assign in_front = ang_mag <= {{(ANG_W-HALF_W){1'b0}}, cfg.front_half_angle_urad};
    assign in_left  = (ang > 32'sd0) && (ang < ONE_RAD);
    assign in_right = (ang < 32'sd0) && (ang > NEG_ONE_RAD);

    assign hit_inc   = s0_rvalid_reg && in_front && (s0_range_reg < cfg.stop_dist_mm)
                       && (front_hits_reg < CNT_CAP);
    assign near_upd  = s0_rvalid_reg && in_front && (s0_range_reg < nearest_reg);
    assign left_inc  = s0_rvalid_reg && in_left && (left_cnt_reg < CNT_CAP);
    assign right_inc = s0_rvalid_reg && in_right && (right_cnt_reg < CNT_CAP);

    always_comb
    begin
        upd.hits       = front_hits_reg + CNT_W'(hit_inc);
        upd.nearest    = near_upd ? s0_range_reg : nearest_reg;
        upd.front_seen = front_seen_reg || (s0_rvalid_reg && in_front);
        upd.left_sum   = left_inc ? left_sum_reg + SUM_W'(s0_range_reg) : left_sum_reg;
        upd.left_cnt   = left_cnt_reg + CNT_W'(left_inc);
        upd.right_sum  = right_inc ? right_sum_reg + SUM_W'(s0_range_reg) : right_sum_reg;
        upd.right_cnt  = right_cnt_reg + CNT_W'(right_inc);
    end

    assign sum       = upd;
    assign sum_valid = s0_valid_reg && s0_end_reg;

    always_comb
    begin
        s0_valid_next   = s0_valid_reg;
        beam_angle_next = beam_angle_reg;
        in_scan_next    = in_scan_reg;
        front_hits_next = front_hits_reg;
        nearest_next    = nearest_reg;
        front_seen_next = front_seen_reg;
        left_sum_next   = left_sum_reg;
        right_sum_next  = right_sum_reg;
        left_cnt_next   = left_cnt_reg;
        right_cnt_next  = right_cnt_reg;
        if (s0_go)
        begin
            s0_valid_next = 1'b0;
            if (s0_end_reg)
            begin
                // scan closes: drop back to an empty scan
                in_scan_next    = 1'b0;
                front_hits_next = '0;
                nearest_next    = NEAREST_NONE;
                front_seen_next = 1'b0;
                left_sum_next   = '0;
                right_sum_next  = '0;
                left_cnt_next   = '0;
                right_cnt_next  = '0;
            end
            else
            begin
                in_scan_next    = 1'b1;
                beam_angle_next = ang_adv;
                front_hits_next = upd.hits;
                nearest_next    = upd.nearest;
                front_seen_next = upd.front_seen;
                left_sum_next   = upd.left_sum;
                right_sum_next  = upd.right_sum;
                left_cnt_next   = upd.left_cnt;
                right_cnt_next  = upd.right_cnt;
            end
        end
        if (accept)
        begin
            s0_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_range_reg  <= sample_ch.range_mm;
            s0_rvalid_reg <= sample_ch.range_valid;
            s0_end_reg    <= sample_ch.scan_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            beam_angle_reg <= '0;
            in_scan_reg    <= 1'b0;
            front_hits_reg <= '0;
            nearest_reg    <= NEAREST_NONE;
            front_seen_reg <= 1'b0;
            left_sum_reg   <= '0;
            right_sum_reg  <= '0;
            left_cnt_reg   <= '0;
            right_cnt_reg  <= '0;
        end
        else
        begin
            s0_valid_reg   <= s0_valid_next;
            beam_angle_reg <= beam_angle_next;
            in_scan_reg    <= in_scan_next;
            front_hits_reg <= front_hits_next;
            nearest_reg    <= nearest_next;
            front_seen_reg <= front_seen_next;
            left_sum_reg   <= left_sum_next;
            right_sum_reg  <= right_sum_next;
            left_cnt_reg   <= left_cnt_next;
            right_cnt_reg  <= right_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_counts_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (front_hits_reg <= CNT_CAP) && (left_cnt_reg <= CNT_CAP)
        && (right_cnt_reg <= CNT_CAP))
        else $error("scan counter beyond cap");

    a_end_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_valid_reg && s0_end_reg && !sum_ready) |=> (s0_valid_reg && s0_end_reg))
        else $error("stalled scan end lost from input register");
`endif
endmodule

@@ src/lfod_decide.sv @@
module lfod_decide (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfod_pkg::cfg_t       cfg,
    input  lfod_pkg::scan_sum_t  sum,
    input  logic                 sum_valid,
    output logic                 sum_ready,
    lfod_result_if.source        result_ch
);
    import lfod_pkg::*;

    // snapshot stage
    logic      d1_valid_reg, d1_valid_next;
    scan_sum_t d1_sum_reg;

    // product stage
    logic               d2_valid_reg, d2_valid_next;
    logic [PROD_W-1:0]  d2_prod_l_reg, d2_prod_r_reg;
    logic               d2_seen_reg;
    logic               d2_clear_ok_reg;
    logic [RANGE_W-1:0] d2_nearest_reg;
    logic [CNT_W-1:0]   d2_hits_reg;

    // decision state and result register
    logic            blocked_reg, blocked_next;
    logic            detour_reg, detour_next;
    logic [CS_W-1:0] clear_scans_reg, clear_scans_next;
    logic            res_valid_reg, res_valid_next;
    result_t         res_reg, res_next;

    logic              res_free, d2_free, d2_go, d1_free, d1_go, d1_load;
    logic              seen, clear_ok;
    logic [SUM_W-1:0]  lnum, rnum;
    logic [CNT_W-1:0]  lden, rden;
    logic [PROD_W-1:0] prod_l, prod_r;
    logic [CS_W-1:0]   cs_inc;

    assign res_free  = !res_valid_reg || result_ch.ready;
    assign d2_free   = !d2_valid_reg || res_free;
    assign d2_go     = d2_valid_reg && res_free;
    assign d1_free   = !d1_valid_reg || d2_free;
    assign d1_go     = d1_valid_reg && d2_free;
    assign sum_ready = d1_free;
    assign d1_load   = sum_valid && sum_ready;

    // empty side stands in as the maximum range over one sample
    assign lnum = (d1_sum_reg.left_cnt != '0) ? d1_sum_reg.left_sum
                                              : SUM_W'(cfg.max_range_mm);
    assign lden = (d1_sum_reg.left_cnt != '0) ? d1_sum_reg.left_cnt : CNT_W'(1);
    assign rnum = (d1_sum_reg.right_cnt != '0) ? d1_sum_reg.right_sum
                                               : SUM_W'(cfg.max_range_mm);
    assign rden = (d1_sum_reg.right_cnt != '0) ? d1_sum_reg.right_cnt : CNT_W'(1);

    assign prod_l   = PROD_W'(lnum) * PROD_W'(rden);
    assign prod_r   = PROD_W'(rnum) * PROD_W'(lden);
    assign seen     = d1_sum_reg.hits >= cfg.required_hits;
    assign clear_ok = !d1_sum_reg.front_seen || (d1_sum_reg.nearest > cfg.clear_dist_mm);

    assign cs_inc = (clear_scans_reg < CLEAR_SCANS_MAX) ? clear_scans_reg + CS_W'(1)
                                                        : clear_scans_reg;

    always_comb
    begin
        d1_valid_next    = d1_load ? 1'b1 : (d1_go ? 1'b0 : d1_valid_reg);
        d2_valid_next    = d1_go ? 1'b1 : (d2_go ? 1'b0 : d2_valid_reg);
        res_valid_next   = d2_go ? 1'b1 : (result_ch.ready ? 1'b0 : res_valid_reg);
        blocked_next     = blocked_reg;
        detour_next      = detour_reg;
        clear_scans_next = clear_scans_reg;
        res_next         = res_reg;
        if (d2_go)
        begin
            if (d2_seen_reg)
            begin
                blocked_next     = 1'b1;
                clear_scans_next = '0;
                // tie goes right
                detour_next      = d2_prod_l_reg > d2_prod_r_reg;
            end
            else if (blocked_reg)
            begin
                clear_scans_next = cs_inc;
                if (d2_clear_ok_reg && (cs_inc > CLEAR_SCANS_NEEDED))
                begin
                    blocked_next = 1'b0;
                end
            end
            res_next.path_blocked     = blocked_next;
            res_next.detour_left      = detour_next;
            res_next.obstacle_seen    = d2_seen_reg;
            res_next.nearest_front_mm = d2_nearest_reg;
            res_next.hit_total        = d2_hits_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d1_load)
        begin
            d1_sum_reg <= sum;
        end
        if (d1_go)
        begin
            d2_prod_l_reg   <= prod_l;
            d2_prod_r_reg   <= prod_r;
            d2_seen_reg     <= seen;
            d2_clear_ok_reg <= clear_ok;
            d2_nearest_reg  <= d1_sum_reg.nearest;
            d2_hits_reg     <= d1_sum_reg.hits;
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg    <= 1'b0;
            d2_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            blocked_reg     <= 1'b0;
            detour_reg      <= 1'b0;
            clear_scans_reg <= '0;
        end
        else
        begin
            d1_valid_reg    <= d1_valid_next;
            d2_valid_reg    <= d2_valid_next;
            res_valid_reg   <= res_valid_next;
            blocked_reg     <= blocked_next;
            detour_reg      <= detour_next;
            clear_scans_reg <= clear_scans_next;
        end
    end

    assign result_ch.valid            = res_valid_reg;
    assign result_ch.path_blocked     = res_reg.path_blocked;
    assign result_ch.detour_left      = res_reg.detour_left;
    assign result_ch.obstacle_seen    = res_reg.obstacle_seen;
    assign result_ch.nearest_front_mm = res_reg.nearest_front_mm;
    assign result_ch.hit_total        = res_reg.hit_total;

`ifndef SYNTHESIS
    a_unblock_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(blocked_reg) |-> (clear_scans_reg > CLEAR_SCANS_NEEDED))
        else $error("unblocked before enough clear scans");

    a_seen_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.obstacle_seen) |-> res_reg.path_blocked)
        else $error("obstacle seen but path not blocked");

    a_seen_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.obstacle_seen) |-> (res_reg.hit_total >= cfg.required_hits))
        else $error("obstacle seen with too few hits");
`endif
endmodule
